FILE: rtl/shcc_pkg.sv
package shcc_pkg;

    // header layout
    localparam logic [5:0]  HDR_LEGACY  = 6'd16;
    localparam logic [5:0]  HDR_CURRENT = 6'd32;

    // magic and header kind bytes
    localparam logic [7:0]  MAGIC_V      = 8'h56;  // 'V'
    localparam logic [7:0]  MAGIC_N      = 8'h4E;  // 'N'
    localparam logic [7:0]  MAGIC_S      = 8'h53;  // 'S'
    localparam logic [7:0]  KIND_LEGACY  = 8'h30;  // '0'
    localparam logic [7:0]  KIND_CURRENT = 8'h56;  // 'V'

    // crc-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    localparam logic [31:0] COUNT_MAX = 32'hFFFFFFFF;
    localparam logic [31:0] SUPPORTED_VERSION_RST = 32'd1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_MAGIC   = 3'd1,
        ST_TRUNCATED   = 3'd2,
        ST_PRE_RELEASE = 3'd3,
        ST_NEWER       = 3'd4,
        ST_INVALID     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        EC_NONE    = 2'd0,
        EC_FORMAT  = 2'd1,
        EC_VERSION = 2'd2
    } err_class_t;

    // word held in the input register
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_word_t;

    // running file state as it stands after the current word
    typedef struct packed {
        logic        overflow;
        logic [31:0] size;
        logic [31:0] crc;
    } stream_view_t;

    // one byte of the reflected crc-32, bit by bit
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

FILE: rtl/shcc_in_stage.sv
module shcc_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                last,
    input  logic                out_free,
    output logic                go,
    output shcc_pkg::in_word_t  word
);

    logic               valid_reg, valid_next;
    shcc_pkg::in_word_t word_reg;
    logic               accept;

    // a non-last word never waits; a last word waits for the result register
    assign go       = valid_reg && (!word_reg.last || out_free);
    assign in_stall = valid_reg && !go;
    assign accept   = in_valid && !in_stall;
    assign word     = word_reg;

    // valid bit of the input register
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (go)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg.data <= data_byte;
            word_reg.last <= last;
        end
    end

endmodule

FILE: rtl/shcc_stream.sv
module shcc_stream (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    go,
    input  shcc_pkg::in_word_t      word,
    output shcc_pkg::stream_view_t  view,
    output logic [31:0][7:0]        hdr_view
);

    logic [31:0]      count_reg;
    logic             ovf_reg;
    logic [31:0]      crc_reg;
    logic [7:0]       hdr_reg [32];

    logic             in_header;
    logic [4:0]       hdr_idx;
    logic             at_max;

    assign in_header = (count_reg[31:5] == 27'd0);
    assign hdr_idx   = count_reg[4:0];
    assign at_max    = (count_reg == shcc_pkg::COUNT_MAX);

    // state after the current word
    always_comb
    begin
        view.overflow = ovf_reg || at_max;
        view.size     = at_max ? count_reg : count_reg + 32'd1;
        view.crc      = in_header ? crc_reg : shcc_pkg::crc_byte(crc_reg, word.data);
    end

    // header bytes with the current word folded in
    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            if (in_header && (hdr_idx == 5'(i)))
                hdr_view[i] = word.data;
            else
                hdr_view[i] = hdr_reg[i];
        end
    end

    // count, crc and overflow; cleared after the last word of a file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 32'd0;
            ovf_reg   <= 1'b0;
            crc_reg   <= shcc_pkg::CRC_ONES;
        end
        else if (go)
        begin
            if (word.last)
            begin
                count_reg <= 32'd0;
                ovf_reg   <= 1'b0;
                crc_reg   <= shcc_pkg::CRC_ONES;
            end
            else
            begin
                count_reg <= view.size;
                ovf_reg   <= view.overflow;
                crc_reg   <= view.crc;
            end
        end
    end

    // header store, kept across files
    always_ff @(posedge clk)
    begin
        if (go && in_header)
            hdr_reg[hdr_idx] <= word.data;
    end

endmodule

FILE: rtl/shcc_finish.sv
module shcc_finish (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  shcc_pkg::stream_view_t  view,
    input  logic [31:0][7:0]        hdr_view,
    input  logic [31:0]             supported_version,
    output logic                    out_free,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              status,
    output logic [1:0]              error_class,
    output logic [31:0]             version,
    output logic [5:0]              header_length,
    output logic [31:0]             slot_id,
    output logic [31:0]             script_position,
    output logic [31:0]             scene_number,
    output logic [31:0]             time_stamp,
    output logic [31:0]             stored_crc,
    output logic [31:0]             payload_length
);

    logic                   out_valid_reg, out_valid_next;
    shcc_pkg::status_t      st_next, st_reg;
    shcc_pkg::err_class_t   ec_next, ec_reg;
    logic [31:0]            ver_next, ver_reg;
    logic [5:0]             hlen_next, hlen_reg;
    logic [31:0]            slot_next, slot_reg;
    logic [31:0]            pc_next, pc_reg;
    logic [31:0]            scene_next, scene_reg;
    logic [31:0]            ts_next, ts_reg;
    logic [31:0]            scrc_next, scrc_reg;
    logic [31:0]            plen_next, plen_reg;

    logic                   magic_ok;
    logic [31:0]            hv_ver;
    logic [31:0]            hv_scrc;
    logic [31:0]            plen_cur;

    assign out_free = !out_valid_reg || !out_stall;

    assign magic_ok = (hdr_view[0] == shcc_pkg::MAGIC_V) &&
                      (hdr_view[1] == shcc_pkg::MAGIC_N) &&
                      (hdr_view[2] == shcc_pkg::MAGIC_S);
    assign hv_ver   = hdr_view[7:4];
    assign hv_scrc  = hdr_view[27:24];
    assign plen_cur = view.size - {26'd0, shcc_pkg::HDR_CURRENT};

    // classify the finished file
    always_comb
    begin
        st_next    = shcc_pkg::ST_INVALID;
        ec_next    = shcc_pkg::EC_FORMAT;
        ver_next   = 32'd0;
        hlen_next  = 6'd0;
        slot_next  = 32'd0;
        pc_next    = 32'd0;
        scene_next = 32'd0;
        ts_next    = 32'd0;
        scrc_next  = 32'd0;
        plen_next  = 32'd0;
        priority if (view.overflow)
        begin
            st_next = shcc_pkg::ST_INVALID;
        end
        else if (view.size[31:4] == 28'd0)
        begin
            st_next = shcc_pkg::ST_TRUNCATED;
        end
        else if (!magic_ok)
        begin
            st_next = shcc_pkg::ST_BAD_MAGIC;
        end
        else if (hdr_view[3] == shcc_pkg::KIND_LEGACY)
        begin
            hlen_next  = shcc_pkg::HDR_LEGACY;
            slot_next  = hdr_view[7:4];
            pc_next    = hdr_view[11:8];
            scene_next = hdr_view[15:12];
            plen_next  = view.size - {26'd0, shcc_pkg::HDR_LEGACY};
            st_next    = shcc_pkg::ST_PRE_RELEASE;
            ec_next    = shcc_pkg::EC_VERSION;
        end
        else if (hdr_view[3] != shcc_pkg::KIND_CURRENT)
        begin
            st_next = shcc_pkg::ST_BAD_MAGIC;
        end
        else if (view.size[31:5] == 27'd0)
        begin
            st_next = shcc_pkg::ST_TRUNCATED;
        end
        else
        begin
            ver_next   = hv_ver;
            hlen_next  = shcc_pkg::HDR_CURRENT;
            slot_next  = hdr_view[11:8];
            pc_next    = hdr_view[15:12];
            scene_next = hdr_view[19:16];
            ts_next    = hdr_view[23:20];
            scrc_next  = hv_scrc;
            plen_next  = plen_cur;
            priority if (hv_ver < supported_version)
            begin
                st_next = shcc_pkg::ST_PRE_RELEASE;
                ec_next = shcc_pkg::EC_VERSION;
            end
            else if (hv_ver > supported_version)
            begin
                st_next = shcc_pkg::ST_NEWER;
                ec_next = shcc_pkg::EC_VERSION;
            end
            else if (hdr_view[31:28] != 32'd0)
            begin
                st_next = shcc_pkg::ST_INVALID;
            end
            else if (plen_cur != 32'd0)
            begin
                if ((view.crc ^ shcc_pkg::CRC_ONES) != hv_scrc)
                    st_next = shcc_pkg::ST_INVALID;
                else
                begin
                    st_next = shcc_pkg::ST_OK;
                    ec_next = shcc_pkg::EC_NONE;
                end
            end
            else if (hv_scrc != 32'd0)
            begin
                st_next = shcc_pkg::ST_INVALID;
            end
            else
            begin
                st_next = shcc_pkg::ST_OK;
                ec_next = shcc_pkg::EC_NONE;
            end
        end
    end

    // result register valid bit
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (fire)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            st_reg    <= st_next;
            ec_reg    <= ec_next;
            ver_reg   <= ver_next;
            hlen_reg  <= hlen_next;
            slot_reg  <= slot_next;
            pc_reg    <= pc_next;
            scene_reg <= scene_next;
            ts_reg    <= ts_next;
            scrc_reg  <= scrc_next;
            plen_reg  <= plen_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = st_reg;
    assign error_class     = ec_reg;
    assign version         = ver_reg;
    assign header_length   = hlen_reg;
    assign slot_id         = slot_reg;
    assign script_position = pc_reg;
    assign scene_number    = scene_reg;
    assign time_stamp      = ts_reg;
    assign stored_crc      = scrc_reg;
    assign payload_length  = plen_reg;

endmodule

FILE: rtl/save_header_check_crc32.sv
// Save-file header checker with payload CRC-32. The file streams in one byte
// per word, header first, with last set on the final byte; exactly one result
// word comes out for that byte, carrying status, error class and the parsed
// header fields. The block takes one byte every cycle unless a last byte is
// held back; the result word is valid from the clock edge after the one that
// takes the last byte, as long as the result register is free, the path being
// the input register, then the byte-wide CRC update and header capture
// feeding the classification logic, then the result register. A stalled
// result holds back the next last byte and those after it; earlier bytes
// keep flowing. There is no clearing pass after reset. supported_version
// may be written only while no file is in flight; it resets to 1.
module save_header_check_crc32 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [1:0]  error_class,
    output logic [31:0] version,
    output logic [5:0]  header_length,
    output logic [31:0] slot_id,
    output logic [31:0] script_position,
    output logic [31:0] scene_number,
    output logic [31:0] time_stamp,
    output logic [31:0] stored_crc,
    output logic [31:0] payload_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic                   go;
    logic                   out_free;
    shcc_pkg::in_word_t     word;
    shcc_pkg::stream_view_t view;
    logic [31:0][7:0]       hdr_view;
    logic [31:0]            supported_version_reg;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            supported_version_reg <= shcc_pkg::SUPPORTED_VERSION_RST;
        else if (cfg_valid && cfg_ready)
            supported_version_reg <= cfg_data;
    end

    shcc_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last      (last),
        .out_free  (out_free),
        .go        (go),
        .word      (word)
    );

    shcc_stream u_stream (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .word     (word),
        .view     (view),
        .hdr_view (hdr_view)
    );

    shcc_finish u_finish (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (go && word.last),
        .view              (view),
        .hdr_view          (hdr_view),
        .supported_version (supported_version_reg),
        .out_free          (out_free),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .error_class       (error_class),
        .version           (version),
        .header_length     (header_length),
        .slot_id           (slot_id),
        .script_position   (script_position),
        .scene_number      (scene_number),
        .time_stamp        (time_stamp),
        .stored_crc        (stored_crc),
        .payload_length    (payload_length)
    );

endmodule

FILE: rtl/shcc_checker.sv
module shcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [1:0]  error_class,
    input logic [31:0] version,
    input logic [5:0]  header_length,
    input logic [31:0] slot_id,
    input logic [31:0] time_stamp,
    input logic [31:0] stored_crc,
    input logic [31:0] payload_length
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(payload_length))
        else $error("result word changed while stalled");

    // error class follows status
    a_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == shcc_pkg::ST_OK) == (error_class == shcc_pkg::EC_NONE)) &&
            (((status == shcc_pkg::ST_PRE_RELEASE) || (status == shcc_pkg::ST_NEWER)) ==
             (error_class == shcc_pkg::EC_VERSION)))
        else $error("error class does not match status");

    // unparsed header reports no fields
    a_unparsed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (header_length == 6'd0) |-> (version == 32'd0) && (slot_id == 32'd0) &&
            (payload_length == 32'd0) && (status != shcc_pkg::ST_OK))
        else $error("fields reported for unparsed header");

    // legacy header is always pre-release with no version, time or crc
    a_legacy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (header_length == shcc_pkg::HDR_LEGACY) |->
            (status == shcc_pkg::ST_PRE_RELEASE) && (version == 32'd0) &&
            (time_stamp == 32'd0) && (stored_crc == 32'd0))
        else $error("bad legacy header result");

    // an ok result comes only from a current header, empty payload needs zero crc
    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == shcc_pkg::ST_OK) |->
            (header_length == shcc_pkg::HDR_CURRENT) &&
            ((payload_length != 32'd0) || (stored_crc == 32'd0)))
        else $error("ok result without a valid current header");

endmodule

bind save_header_check_crc32 shcc_checker u_shcc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .error_class    (error_class),
    .version        (version),
    .header_length  (header_length),
    .slot_id        (slot_id),
    .time_stamp     (time_stamp),
    .stored_crc     (stored_crc),
    .payload_length (payload_length)
);

FILE: tb/tb_save_header_check_crc32.sv
`timescale 1ns / 100ps

module tb_save_header_check_crc32;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MISMATCH_PRINTS = 40;

    // what the header check is expected to report for one file
    typedef struct {
        shcc_pkg::status_t     status;
        shcc_pkg::err_class_t  eclass;
        logic [31:0] version;
        logic [5:0]  hlen;
        logic [31:0] slot;
        logic [31:0] pos;
        logic [31:0] scene;
        logic [31:0] stamp;
        logic [31:0] scrc;
        logic [31:0] plen;
    } file_verdict_t;

    // shapes of save file the stimulus can build
    typedef enum {
        FK_GOOD,
        FK_BAD_CRC,
        FK_RESERVED,
        FK_VER_LOW,
        FK_VER_HIGH,
        FK_LEGACY,
        FK_BAD_MAGIC,
        FK_BAD_KIND,
        FK_SHORT,
        FK_SHORT_CURRENT,
        FK_NOISE
    } file_kind_t;

    // running copy of the file parser, plus the verdicts still owed
    class save_check_scoreboard;
        logic [31:0]   accepted_version;
        logic [31:0]   file_bytes;
        logic [7:0]    hdr [32];
        logic [31:0]   crc_run;
        bit            overflow;
        file_verdict_t verdicts_due[$];
        int            errors;
        int            mismatches;
        int            verdicts_checked;

        function new();
            accepted_version = shcc_pkg::SUPPORTED_VERSION_RST;
            file_bytes = '0;
            crc_run = shcc_pkg::CRC_ONES;
            overflow = 1'b0;
            foreach (hdr[i])
                hdr[i] = '0;
            errors = 0;
            mismatches = 0;
            verdicts_checked = 0;
        endfunction

        // reflected crc-32, one data bit at a time, lsb first
        static function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
            logic [31:0] c;
            c = crc;
            for (int i = 0; i < 8; i++)
            begin
                if (c[0] ^ b[i])
                    c = (c >> 1) ^ shcc_pkg::CRC_POLY;
                else
                    c = c >> 1;
            end
            return c;
        endfunction

        function logic [31:0] word_at(int unsigned at);
            return {hdr[(at + 3) % 32], hdr[(at + 2) % 32], hdr[(at + 1) % 32], hdr[at % 32]};
        endfunction

        // classify the file that just ended
        function file_verdict_t close_file();
            file_verdict_t r;
            r.status  = shcc_pkg::ST_INVALID;
            r.eclass  = shcc_pkg::EC_FORMAT;
            r.version = '0;
            r.hlen    = '0;
            r.slot    = '0;
            r.pos     = '0;
            r.scene   = '0;
            r.stamp   = '0;
            r.scrc    = '0;
            r.plen    = '0;
            if (overflow)
                r.status = shcc_pkg::ST_INVALID;
            else if (file_bytes < shcc_pkg::HDR_LEGACY)
                r.status = shcc_pkg::ST_TRUNCATED;
            else if (hdr[0] != shcc_pkg::MAGIC_V || hdr[1] != shcc_pkg::MAGIC_N ||
                     hdr[2] != shcc_pkg::MAGIC_S)
                r.status = shcc_pkg::ST_BAD_MAGIC;
            else if (hdr[3] == shcc_pkg::KIND_LEGACY)
            begin
                r.hlen   = shcc_pkg::HDR_LEGACY;
                r.slot   = word_at(4);
                r.pos    = word_at(8);
                r.scene  = word_at(12);
                r.plen   = file_bytes - 32'(shcc_pkg::HDR_LEGACY);
                r.status = shcc_pkg::ST_PRE_RELEASE;
                r.eclass = shcc_pkg::EC_VERSION;
            end
            else if (hdr[3] != shcc_pkg::KIND_CURRENT)
                r.status = shcc_pkg::ST_BAD_MAGIC;
            else if (file_bytes < shcc_pkg::HDR_CURRENT)
                r.status = shcc_pkg::ST_TRUNCATED;
            else
            begin
                r.version = word_at(4);
                r.hlen    = shcc_pkg::HDR_CURRENT;
                r.slot    = word_at(8);
                r.pos     = word_at(12);
                r.scene   = word_at(16);
                r.stamp   = word_at(20);
                r.scrc    = word_at(24);
                r.plen    = file_bytes - 32'(shcc_pkg::HDR_CURRENT);
                if (r.version < accepted_version)
                begin
                    r.status = shcc_pkg::ST_PRE_RELEASE;
                    r.eclass = shcc_pkg::EC_VERSION;
                end
                else if (r.version > accepted_version)
                begin
                    r.status = shcc_pkg::ST_NEWER;
                    r.eclass = shcc_pkg::EC_VERSION;
                end
                else if (word_at(28) != 0)
                    r.status = shcc_pkg::ST_INVALID;
                else if (r.plen != 0 && (crc_run ^ shcc_pkg::CRC_ONES) != r.scrc)
                    r.status = shcc_pkg::ST_INVALID;
                else if (r.plen == 0 && r.scrc != 0)
                    r.status = shcc_pkg::ST_INVALID;
                else
                begin
                    r.status = shcc_pkg::ST_OK;
                    r.eclass = shcc_pkg::EC_NONE;
                end
            end
            return r;
        endfunction

        // one accepted input word
        function void take_byte(logic [7:0] b, logic fin);
            if (file_bytes < shcc_pkg::HDR_CURRENT)
                hdr[file_bytes[4:0]] = b;
            else
                crc_run = crc_step(crc_run, b);
            if (file_bytes == shcc_pkg::COUNT_MAX)
                overflow = 1'b1;
            else
                file_bytes++;
            if (fin)
            begin
                verdicts_due.push_back(close_file());
                file_bytes = '0;
                crc_run = shcc_pkg::CRC_ONES;
                overflow = 1'b0;
            end
        endfunction

        function bit same(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= MISMATCH_PRINTS)
                    $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        // one accepted result word against the oldest verdict owed
        function void check_verdict(logic [2:0] st, logic [1:0] ec, logic [31:0] ver,
                                    logic [5:0] hl, logic [31:0] slot, logic [31:0] pos,
                                    logic [31:0] scene, logic [31:0] stamp,
                                    logic [31:0] scrc, logic [31:0] plen);
            file_verdict_t e;
            bit ok;
            verdicts_checked++;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none actual status %0d",
                         $time, st);
                errors++;
                return;
            end
            e = verdicts_due.pop_front();
            ok = 1'b1;
            ok &= same("status", e.status, st);
            ok &= same("error_class", e.eclass, ec);
            ok &= same("version", e.version, ver);
            ok &= same("header_length", e.hlen, hl);
            ok &= same("slot_id", e.slot, slot);
            ok &= same("script_position", e.pos, pos);
            ok &= same("scene_number", e.scene, scene);
            ok &= same("time_stamp", e.stamp, stamp);
            ok &= same("stored_crc", e.scrc, scrc);
            ok &= same("payload_length", e.plen, plen);
            if (!ok)
                errors++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [1:0]  error_class;
    logic [31:0] version;
    logic [5:0]  header_length;
    logic [31:0] slot_id;
    logic [31:0] script_position;
    logic [31:0] scene_number;
    logic [31:0] time_stamp;
    logic [31:0] stored_crc;
    logic [31:0] payload_length;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    save_check_scoreboard book;
    logic [31:0] cur_version = shcc_pkg::SUPPORTED_VERSION_RST;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    int          files_sent = 0;
    int          settings_used = 0;

    save_header_check_crc32 dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .last            (last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .error_class     (error_class),
        .version         (version),
        .header_length   (header_length),
        .slot_id         (slot_id),
        .script_position (script_position),
        .scene_number    (scene_number),
        .time_stamp      (time_stamp),
        .stored_crc      (stored_crc),
        .payload_length  (payload_length),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always #5 clk = ~clk;

    // receiver backpressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result words, sampled as they stand before the edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.check_verdict(status, error_class, version, header_length, slot_id,
                               script_position, scene_number, time_stamp, stored_crc,
                               payload_length);
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("cycle limit of %0d reached with %0d results outstanding",
                 CYCLE_LIMIT, book.verdicts_due.size());
        $display("tb_save_header_check_crc32: FAIL");
        $finish;
    end

    // one input word, with random sender gaps ahead of it
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= fin;
        do
            @(posedge clk);
        while (in_stall);
        book.take_byte(b, fin);
        bytes_sent++;
    endtask

    // build one save file of the given shape and stream it in
    // fill: 0 random header fields, 1 all zero, 2 all ones; keep: forced length
    task automatic send_file(input file_kind_t kind, input int unsigned body_len,
                             input int fill, input int unsigned keep);
        logic [7:0]  img[$];
        logic [7:0]  body[$];
        logic [31:0] words[7];
        logic [31:0] crc;
        logic [7:0]  b;
        int unsigned cut;
        int          first;
        crc = shcc_pkg::CRC_ONES;
        for (int i = 0; i < body_len; i++)
        begin
            body.push_back(8'($urandom_range(255)));
            crc = save_check_scoreboard::crc_step(crc, body[i]);
        end
        if (kind == FK_NOISE)
        begin
            cut = (keep != 0) ? keep : $urandom_range(1, 48);
            for (int i = 0; i < cut; i++)
                img.push_back(8'($urandom_range(255)));
        end
        else
        begin
            // header words: version, slot, position, scene, stamp, crc, reserved
            words[0] = cur_version;
            if (kind == FK_VER_LOW)
                words[0] = cur_version - 1;
            else if (kind == FK_VER_HIGH)
                words[0] = cur_version + 1;
            for (int w = 1; w < 5; w++)
                words[w] = (fill == 1) ? 32'd0 : (fill == 2) ? 32'hFFFFFFFF : $urandom;
            words[5] = (body_len != 0) ? (crc ^ shcc_pkg::CRC_ONES) : 32'd0;
            if (kind == FK_BAD_CRC)
                words[5] ^= 32'd1 << $urandom_range(31);
            words[6] = '0;
            if (kind == FK_RESERVED)
                words[6] = $urandom | (32'd1 << $urandom_range(31));
            img.push_back(shcc_pkg::MAGIC_V);
            img.push_back(shcc_pkg::MAGIC_N);
            img.push_back(shcc_pkg::MAGIC_S);
            img.push_back((kind == FK_LEGACY) ? shcc_pkg::KIND_LEGACY
                                              : shcc_pkg::KIND_CURRENT);
            first = (kind == FK_LEGACY) ? 1 : 0;
            for (int w = first; w < ((kind == FK_LEGACY) ? 4 : 7); w++)
                for (int k = 0; k < 4; k++)
                    img.push_back(words[w][8*k +: 8]);
            img = {img, body};
            if (kind == FK_BAD_MAGIC)
            begin
                cut = $urandom_range(2);
                img[cut] ^= 8'($urandom_range(1, 255));
            end
            if (kind == FK_BAD_KIND)
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == shcc_pkg::KIND_LEGACY || b == shcc_pkg::KIND_CURRENT);
                img[3] = b;
            end
            // truncation
            if (keep != 0)
                cut = keep;
            else if (kind == FK_SHORT)
                cut = $urandom_range(1, 15);
            else if (kind == FK_SHORT_CURRENT)
                cut = $urandom_range(16, 31);
            else
                cut = img.size();
            if (cut < img.size())
                img = img[0:cut-1];
        end
        foreach (img[i])
            send_byte(img[i], i == img.size() - 1);
        files_sent++;
    endtask

    // let every owed result come back before returning, with the input idle
    task automatic drain();
        in_valid <= 1'b0;
        while (book.verdicts_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_version(input logic [31:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        book.accepted_version = v;
        cur_version = v;
        settings_used++;
    endtask

    initial
    begin
        logic [31:0] settings[9];
        int          target;
        int          pick;
        int unsigned body_len;
        file_kind_t  kind;

        book = new();
        settings = '{32'd0, 32'hFFFFFFFF, $urandom, 32'd2, 32'h80000000,
                     $urandom, 32'd1, $urandom, 32'hFFFFFFFE};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed files at the reset version
        send_idle_pct = 10;
        recv_stall_pct = 64;
        send_file(FK_GOOD, 0, 0, 0);
        send_file(FK_GOOD, 1, 1, 0);
        send_file(FK_GOOD, 5, 2, 0);
        send_file(FK_BAD_CRC, 0, 0, 0);
        send_file(FK_BAD_CRC, 4, 0, 0);
        send_file(FK_RESERVED, 2, 0, 0);
        send_file(FK_VER_LOW, 2, 0, 0);
        send_file(FK_VER_HIGH, 2, 0, 0);
        send_file(FK_LEGACY, 0, 0, 0);
        send_file(FK_LEGACY, 3, 2, 0);
        send_file(FK_BAD_MAGIC, 1, 0, 0);
        send_file(FK_BAD_MAGIC, 1, 0, 0);
        send_file(FK_BAD_MAGIC, 1, 0, 0);
        send_file(FK_BAD_KIND, 1, 0, 0);
        send_file(FK_SHORT, 0, 0, 1);
        send_file(FK_SHORT, 0, 0, 15);
        send_file(FK_SHORT_CURRENT, 0, 0, 16);
        send_file(FK_SHORT_CURRENT, 0, 0, 31);
        send_file(FK_NOISE, 0, 0, 0);

        // version register at its extremes
        write_version(32'd0);
        send_file(FK_GOOD, 3, 0, 0);
        send_file(FK_VER_HIGH, 0, 0, 0);
        send_file(FK_VER_LOW, 1, 0, 0);
        write_version(32'hFFFFFFFF);
        send_file(FK_GOOD, 2, 2, 0);
        send_file(FK_VER_LOW, 2, 0, 0);

        // random files in three idling phases, three register settings each
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct  = (ph == 0) ? 10 : (ph == 1) ? 64 : 0;
            recv_stall_pct = (ph == 0) ? 64 : (ph == 1) ? 10 : 0;
            for (int seg = 0; seg < 3; seg++)
            begin
                write_version(settings[ph*3 + seg]);
                target = bytes_sent + 60;
                while (bytes_sent < target)
                begin
                    pick = $urandom_range(99);
                    if (pick < 55)
                        kind = FK_GOOD;
                    else if (pick < 61)
                        kind = FK_BAD_CRC;
                    else if (pick < 65)
                        kind = FK_RESERVED;
                    else if (pick < 70)
                        kind = FK_VER_LOW;
                    else if (pick < 75)
                        kind = FK_VER_HIGH;
                    else if (pick < 81)
                        kind = FK_LEGACY;
                    else if (pick < 85)
                        kind = FK_BAD_MAGIC;
                    else if (pick < 88)
                        kind = FK_BAD_KIND;
                    else if (pick < 92)
                        kind = FK_SHORT;
                    else if (pick < 95)
                        kind = FK_SHORT_CURRENT;
                    else
                        kind = FK_NOISE;
                    body_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 14);
                    send_file(kind, body_len, 0, 0);
                end
            end
        end

        // wind down
        drain();
        repeat (8) @(posedge clk);
        if (book.verdicts_due.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, book.verdicts_due.size());
            book.errors++;
        end
        $display("run covered %0d files in %0d bytes, %0d results checked",
                 files_sent, bytes_sent, book.verdicts_checked);
        $display("version register written %0d times, sender and receiver gaps varied",
                 settings_used);
        if (book.errors == 0)
            $display("tb_save_header_check_crc32: PASS");
        else
            $display("tb_save_header_check_crc32: FAIL");
        $finish;
    end

endmodule

FILE: save_header_check_crc32.f
rtl/shcc_pkg.sv
rtl/shcc_in_stage.sv
rtl/shcc_stream.sv
rtl/shcc_finish.sv
rtl/save_header_check_crc32.sv
rtl/shcc_checker.sv
tb/tb_save_header_check_crc32.sv
